### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the lph_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Types and codes of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int TABLE_SIZE_DEF = 16;
   localparam int KEY_W          = 32;
   localparam int MODE_W         = 2;
   localparam int STATUS_W       = 2;
   localparam int SLOT_W         = 4;
   localparam int MODULUS_W      = 5;
   localparam int SSTATE_W       = 2;

   localparam logic [MODULUS_W-1:0] MODULUS_RESET = 5'd10;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [SSTATE_W-1:0] SLOT_EMPTY = 2'd0;
   localparam logic [SSTATE_W-1:0] SLOT_USED  = 2'd1;
   localparam logic [SSTATE_W-1:0] SLOT_TOMB  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

endpackage

### rtl/core/linear_probe_hash_table.sv
// Sequence: an unused mode goes from idle straight to the result; insert,
//   search and delete run a 32-step divider, then table-size reductions, then
//   1..TABLE_SIZE probes (a read and a check each) before the result.
// Throughput: one item at a time; the next is taken after the result leaves.
// Reset: synchronous; a clearing pass over all TABLE_SIZE slots empties the
//   slot table while req_stall stays high. modulus resets to 10.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed key table with linear probing and tombstones.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lph_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lph_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [lph_pkg::MODULUS_W-1:0] csr_data
);
   import lph_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [SSTATE_W-1:0] slot_mem [TABLE_SIZE];
   logic [KEY_W-1:0]    key_mem  [TABLE_SIZE];

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     free_ff, free_in;
   logic [IDX_W-1:0]     hit_ff, hit_in;
   logic                 found_ff, found_in;
   logic                 has_free_ff, has_free_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   rsp_type              rsp_ff, rsp_in;
   logic [MODULUS_W-1:0] modulus_ff;
   logic [SSTATE_W-1:0]  slot_rd_ff;
   logic [KEY_W-1:0]     key_rd_ff;

   logic                 accept, op_valid, hash_start, hash_done;
   logic [IDX_W-1:0]     hash_home;
   logic [MODULUS_W-1:0] divisor;
   logic                 slot_we, key_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [SSTATE_W-1:0]  wr_state;

   assign accept     = req_valid && !req_stall;
   assign op_valid   = (req_data.mode == MODE_INSERT) || (req_data.mode == MODE_SEARCH) ||
                       (req_data.mode == MODE_DELETE);
   assign hash_start = accept && op_valid;
   assign divisor    = (modulus_ff == '0) ? MODULUS_W'(1) : modulus_ff;

   lph_home_unit #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_home (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (req_data.key),
      .divisor (divisor),
      .done    (hash_done),
      .home    (hash_home)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      free_in     = free_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      has_free_in = has_free_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      rsp_in      = rsp_ff;
      slot_we     = 1'b0;
      key_we      = 1'b0;
      wr_addr     = clr_ff;
      wr_state    = SLOT_EMPTY;
      case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               key_in  = req_data.key;
               if (op_valid) begin
                  state_in = S_HASH;
               end else begin
                  rsp_in.status = STATUS_MISS;
                  rsp_in.slot   = '0;
                  state_in      = S_RESP;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               pos_in      = hash_home;
               count_in    = '0;
               found_in    = 1'b0;
               has_free_in = 1'b0;
               free_in     = '0;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (slot_rd_ff == SLOT_EMPTY) begin
               if (!has_free_ff) begin
                  has_free_in = 1'b1;
                  free_in     = pos_ff;
               end
               state_in = S_FIN;
            end else if (slot_rd_ff == SLOT_USED && key_rd_ff == key_ff) begin
               found_in = 1'b1;
               hit_in   = pos_ff;
               state_in = S_FIN;
            end else begin
               if (slot_rd_ff != SLOT_USED && !has_free_ff) begin
                  has_free_in = 1'b1;
                  free_in     = pos_ff;
               end
               if (count_ff == LAST_IDX) begin
                  state_in = S_FIN;
               end else begin
                  count_in = count_ff + 1'b1;
                  pos_in   = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_FIN: begin
            rsp_in.status = STATUS_MISS;
            rsp_in.slot   = '0;
            if (found_ff) begin
               rsp_in.status = STATUS_DONE;
               rsp_in.slot   = SLOT_W'(hit_ff);
               if (mode_ff == MODE_DELETE) begin
                  slot_we  = 1'b1;
                  wr_addr  = hit_ff;
                  wr_state = SLOT_TOMB;
               end
            end else if (mode_ff == MODE_INSERT) begin
               if (has_free_ff) begin
                  slot_we       = 1'b1;
                  key_we        = 1'b1;
                  wr_addr       = free_ff;
                  wr_state      = SLOT_USED;
                  rsp_in.status = STATUS_DONE;
                  rsp_in.slot   = SLOT_W'(free_ff);
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         modulus_ff <= MODULUS_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_write) begin
            modulus_ff <= csr_data;
         end
      end
      pos_ff      <= pos_in;
      count_ff    <= count_in;
      free_ff     <= free_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      has_free_ff <= has_free_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[wr_addr] <= wr_state;
      end
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      slot_rd_ff <= slot_mem[pos_ff];
      key_rd_ff  <= key_mem[pos_ff];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/lph_home_unit.sv
// ----------------------------------------------------------------------------
// lph_home_unit
// Home slot: key mod divisor, then mod table size, on one shared
// subtractor (restoring division one bit per cycle, then reduction).
// ----------------------------------------------------------------------------
module lph_home_unit #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lph_pkg::KEY_W-1:0]         key,
   input  logic [lph_pkg::MODULUS_W-1:0]     divisor,
   output logic                              done,
   output logic [$clog2(TABLE_SIZE)-1:0]     home
);
   import lph_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int SUB_W = (IDX_W + 1 > MODULUS_W + 1) ? IDX_W + 1 : MODULUS_W + 1;
   localparam int CNT_W = $clog2(KEY_W);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_RED  = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SUB_W-1:0] rem_ff, rem_in;
   logic [SUB_W-1:0] op_a, op_b, diff, res;
   logic             ge;

   always_comb begin
      op_a = (phase_ff == PH_RED) ? rem_ff : {rem_ff[SUB_W-2:0], key_ff[KEY_W-1]};
      op_b = (phase_ff == PH_RED) ? SUB_W'(TABLE_SIZE) : SUB_W'(divisor);
      ge   = (op_a >= op_b);
      diff = op_a - op_b;
      res  = ge ? diff : op_a;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      key_in   = key_ff;
      rem_in   = rem_ff;
      done     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               key_in   = key;
               rem_in   = '0;
               count_in = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in   = res;
            key_in   = {key_ff[KEY_W-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(KEY_W - 1)) begin
               phase_in = PH_RED;
            end
         end
         PH_RED: begin
            if (ge) begin
               rem_in = diff;
            end else begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   assign home = rem_ff[IDX_W-1:0];

endmodule

### rtl/core/lph_checker.sv
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lph_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lph_pkg::rsp_type rsp_data
);
   import lph_pkg::*;

   logic req_xfer;
   logic rsp_miss;
   logic rsp_wait;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_miss = rsp_valid && (rsp_data.status != STATUS_DONE);
   assign rsp_wait = rsp_valid && rsp_stall;

   // one item in flight: a result is only shown while requests are held off
   `ASSERT_CLK(a_rsp_blocks_req, clock, reset, rsp_valid |-> req_stall, "result with req open")
   // an accepted request closes the input side
   `ASSERT_CLK(a_accept_stalls, clock, reset, req_xfer |=> req_stall, "no stall after transfer")
   // miss and full report slot zero
   `ASSERT_CLK(a_miss_slot_zero, clock, reset, rsp_miss |-> (rsp_data.slot == '0), "slot on miss")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_data), "rsp moved")
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result after reset")

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);
